/* src/clock_page_replacement_defines.svh */
// Assertion macros for the RTL of the page replacement engine.
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS
// Check on the rising clock edge, switched off while reset is high.
`define CPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication check, same clocking and reset as above.
`define CPR_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define CPR_ASSERT(lbl, clk, rst, prop, msg)
`define CPR_ASSERT_IMP(lbl, clk, rst, pre, post, msg)
`endif

`endif

/* src/cpr_pkg.sv */
`default_nettype none

package cpr_pkg;

   localparam int ENTRY_W  = 10;
   localparam int FRAME_W  = 8;
   localparam int REF_BIT  = 0;
   localparam int PRES_BIT = 1;

   localparam logic [7:0] FRAME_COUNT_RST = 8'd4;
   localparam logic [8:0] PAGE_COUNT_RST  = 9'd256;

   localparam logic [2:0] STATUS_HIT     = 3'd0;
   localparam logic [2:0] STATUS_FREE    = 3'd1;
   localparam logic [2:0] STATUS_EVICT   = 3'd2;
   localparam logic [2:0] STATUS_REJECT  = 3'd3;
   localparam logic [2:0] STATUS_RESTART = 3'd4;

   localparam logic MODE_REF     = 1'b0;
   localparam logic MODE_RESTART = 1'b1;

   localparam logic CSR_FRAME_COUNT = 1'b0;
   localparam logic CSR_PAGE_COUNT  = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] page_number;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  frame_idx;
      logic [7:0]  victim_page;
      logic [15:0] fault_total;
   } rsp_type;

endpackage

`default_nettype wire

/* src/cpr_ram.sv */
`default_nettype none

module cpr_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/clock_page_replacement.sv */
// Clock (second chance) page replacement engine, one page reference per transaction.
// Steps from accept to result strobe: a rejected page is answered from idle, a hit
// looks up its entry, a fault into a free frame looks then loads, and an eviction
// looks, then checks up to 2*count+1 entries at the hand (count: effective page range)
// and then loads. busy drops as the result is shown; requests never overlap; there is
// no receiver stall. Reset (synchronous, active high) clears the table, busy high.
`default_nettype none
`include "clock_page_replacement_defines.svh"

module clock_page_replacement #(
   parameter int PAGES_MAX = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output      logic            busy,
   input  wire cpr_pkg::req_type req_data,
   output      logic            rsp_strobe,
   output      cpr_pkg::rsp_type rsp_data,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [2:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output      logic [31:0]     prdata,
   output      logic            pready
);

   localparam int AW = $clog2(PAGES_MAX);
   localparam int CW = $clog2(PAGES_MAX + 1);
   localparam int SW = $clog2(2 * PAGES_MAX + 2);
   localparam int EW = cpr_pkg::ENTRY_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_LOOK   = 3'd2;
   localparam logic [2:0] S_SW_RD  = 3'd3;
   localparam logic [2:0] S_SW_CHK = 3'd4;
   localparam logic [2:0] S_LOAD   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    page_ff, page_in;
   logic [AW-1:0]    hand_ff, hand_in;
   logic [SW-1:0]    steps_ff, steps_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             restart_ff, restart_in;
   logic [7:0]       free_ff, free_in;
   logic [15:0]      faults_ff, faults_in;
   logic [7:0]       frame_ff, frame_in;
   logic [AW-1:0]    victim_ff, victim_in;
   logic [2:0]       status_ff, status_in;
   logic             strobe_ff, strobe_in;
   cpr_pkg::rsp_type rsp_ff, rsp_in;
   logic [7:0]       frame_count_ff, frame_count_in;
   logic [8:0]       page_count_ff, page_count_in;

   logic [CW-1:0]    count;
   logic [SW-1:0]    sweep_limit;
   logic [AW-1:0]    hand_next;
   logic [15:0]      faults_inc;
   logic             accept;
   logic             reject;
   logic             csr_write;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [EW-1:0]    ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [EW-1:0]    ram_rdata;

   cpr_ram #(
      .WIDTH(EW),
      .DEPTH(PAGES_MAX)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // page_count of zero or above the table size means the whole table
   assign count = (page_count_ff == '0 || 32'(page_count_ff) > PAGES_MAX)
                  ? CW'(PAGES_MAX) : CW'(page_count_ff);
   assign sweep_limit = SW'({count, 1'b0});
   assign hand_next   = (CW'(hand_ff) + CW'(1) == count) ? '0 : hand_ff + AW'(1);
   assign faults_inc  = (faults_ff != 16'hFFFF) ? faults_ff + 16'd1 : faults_ff;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign reject = 32'(req_data.page_number) >= 32'(count);
   assign ram_raddr = (state_ff == S_IDLE) ? AW'(req_data.page_number) :
                      (state_ff == S_SW_RD) ? hand_ff : page_ff;

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == cpr_pkg::CSR_PAGE_COUNT) ? {23'd0, page_count_ff}
                                                          : {24'd0, frame_count_ff};

   always_comb begin
      frame_count_in = frame_count_ff;
      page_count_in  = page_count_ff;
      if (csr_write) begin
         if (paddr[2] == cpr_pkg::CSR_PAGE_COUNT) begin
            page_count_in = pwdata[8:0];
         end else begin
            frame_count_in = pwdata[7:0];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      page_in    = page_ff;
      hand_in    = hand_ff;
      steps_in   = steps_ff;
      clr_in     = clr_ff;
      restart_in = restart_ff;
      free_in    = free_ff;
      faults_in  = faults_ff;
      frame_in   = frame_ff;
      victim_in  = victim_ff;
      status_in  = status_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      ram_waddr  = page_ff;
      ram_wdata  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.mode == cpr_pkg::MODE_RESTART) begin
                  state_in   = S_CLEAR;
                  clr_in     = '0;
                  restart_in = 1'b1;
                  free_in    = frame_count_ff;
               end else if (reject) begin
                  strobe_in             = 1'b1;
                  rsp_in.status         = cpr_pkg::STATUS_REJECT;
                  rsp_in.frame_idx      = '0;
                  rsp_in.victim_page    = '0;
                  rsp_in.fault_total    = faults_ff;
               end else begin
                  page_in  = AW'(req_data.page_number);
                  state_in = S_LOOK;
               end
            end
         end
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(PAGES_MAX - 1)) begin
               state_in  = S_IDLE;
               hand_in   = '0;
               faults_in = '0;
               if (restart_ff) begin
                  strobe_in = 1'b1;
                  rsp_in    = '{status: cpr_pkg::STATUS_RESTART, frame_idx: 8'd0,
                                victim_page: 8'd0, fault_total: 16'd0};
               end
            end
         end
         S_LOOK: begin
            if (ram_rdata[cpr_pkg::PRES_BIT]) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               ram_wdata[cpr_pkg::REF_BIT] = 1'b1;
               strobe_in = 1'b1;
               rsp_in    = '{status: cpr_pkg::STATUS_HIT,
                             frame_idx: ram_rdata[EW-1:2],
                             victim_page: 8'd0, fault_total: faults_ff};
               state_in  = S_IDLE;
            end else if (free_ff != 8'd0) begin
               free_in   = free_ff - 8'd1;
               frame_in  = free_ff - 8'd1;
               status_in = cpr_pkg::STATUS_FREE;
               state_in  = S_LOAD;
            end else begin
               if (CW'(hand_ff) >= count) begin
                  hand_in = '0;
               end
               steps_in = '0;
               state_in = S_SW_RD;
            end
         end
         S_SW_RD: begin
            state_in = S_SW_CHK;
         end
         S_SW_CHK: begin
            ram_waddr = hand_ff;
            if (ram_rdata[cpr_pkg::PRES_BIT] && !ram_rdata[cpr_pkg::REF_BIT]) begin
               // victim found: free its entry, hand stays on it
               ram_we    = 1'b1;
               ram_wdata = '0;
               frame_in  = ram_rdata[EW-1:2];
               victim_in = hand_ff;
               status_in = cpr_pkg::STATUS_EVICT;
               state_in  = S_LOAD;
            end else begin
               if (ram_rdata[cpr_pkg::PRES_BIT]) begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata;
                  ram_wdata[cpr_pkg::REF_BIT] = 1'b0;
               end
               hand_in = hand_next;
               if (steps_ff == sweep_limit) begin
                  // nothing resident in range: load into frame zero
                  frame_in  = 8'd0;
                  status_in = cpr_pkg::STATUS_FREE;
                  state_in  = S_LOAD;
               end else begin
                  steps_in = steps_ff + SW'(1);
                  state_in = S_SW_RD;
               end
            end
         end
         S_LOAD: begin
            ram_we    = 1'b1;
            ram_wdata = {frame_ff, 1'b1, 1'b1};
            faults_in = faults_inc;
            strobe_in = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.frame_idx    = frame_ff;
            rsp_in.victim_page  = (status_ff == cpr_pkg::STATUS_EVICT) ? 8'(victim_ff) : 8'd0;
            rsp_in.fault_total  = faults_inc;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         restart_ff     <= 1'b0;
         hand_ff        <= '0;
         free_ff        <= cpr_pkg::FRAME_COUNT_RST;
         faults_ff      <= '0;
         strobe_ff      <= 1'b0;
         frame_count_ff <= cpr_pkg::FRAME_COUNT_RST;
         page_count_ff  <= cpr_pkg::PAGE_COUNT_RST;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         restart_ff     <= restart_in;
         hand_ff        <= hand_in;
         free_ff        <= free_in;
         faults_ff      <= faults_in;
         strobe_ff      <= strobe_in;
         frame_count_ff <= frame_count_in;
         page_count_ff  <= page_count_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      steps_ff  <= steps_in;
      frame_ff  <= frame_in;
      victim_ff <= victim_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `CPR_ASSERT_IMP(a_hand_in_range, clock, reset,
      state_ff == S_SW_RD || state_ff == S_SW_CHK, CW'(hand_ff) < count,
      "clock hand outside page range during sweep")
   `CPR_ASSERT_IMP(a_sweep_bounded, clock, reset,
      state_ff == S_SW_CHK, steps_ff <= sweep_limit,
      "sweep ran past its step limit")
   `CPR_ASSERT_IMP(a_chk_after_rd, clock, reset,
      state_ff == S_SW_CHK, $past(state_ff) == S_SW_RD,
      "table check without a preceding read")
   `CPR_ASSERT_IMP(a_evict_from_load, clock, reset,
      strobe_ff && rsp_ff.status == cpr_pkg::STATUS_EVICT, $past(state_ff) == S_LOAD,
      "eviction result not issued from load step")
   `CPR_ASSERT(a_ref_progress, clock, reset,
      (accept && req_data.mode == cpr_pkg::MODE_REF) |=> (busy || strobe_ff),
      "page reference neither answered nor in progress")

endmodule

`default_nettype wire

/* tb/testbench.sv */
module testbench;

   localparam int PAGE_LIMIT     = 256;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 100;

   // Page table model with its own copy of the registers and the clock hand.
   class fault_scoreboard;
      logic [7:0]                  frames_reg;
      logic [8:0]                  pages_reg;
      logic [cpr_pkg::ENTRY_W-1:0] pte [PAGE_LIMIT];
      int                          hand_pos;
      logic [7:0]                  free_left;
      logic [15:0]                 fault_cnt;
      cpr_pkg::rsp_type            pending [$];
      int                          mismatches;
      int                          status_seen [5];

      function new();
         frames_reg = cpr_pkg::FRAME_COUNT_RST;
         pages_reg  = cpr_pkg::PAGE_COUNT_RST;
         mismatches = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_state();
      endfunction

      function void clear_state();
         foreach (pte[i]) pte[i] = '0;
         hand_pos  = 0;
         free_left = frames_reg;
         fault_cnt = '0;
      endfunction

      function void set_register(logic index, logic [31:0] value);
         if (index == cpr_pkg::CSR_FRAME_COUNT) begin
            frames_reg = value[7:0];
         end else begin
            pages_reg = value[8:0];
         end
      endfunction

      function void note_request(cpr_pkg::req_type item);
         cpr_pkg::rsp_type want;
         int               span;
         int               steps;
         int               victim;
         logic [7:0]       frame;
         bit               found;
         want = '0;
         span = (pages_reg == 0 || pages_reg > PAGE_LIMIT) ? PAGE_LIMIT : int'(pages_reg);
         if (item.mode == cpr_pkg::MODE_RESTART) begin
            clear_state();
            want.status = cpr_pkg::STATUS_RESTART;
         end else if (item.page_number >= span) begin
            want.status      = cpr_pkg::STATUS_REJECT;
            want.fault_total = fault_cnt;
         end else if (pte[item.page_number][cpr_pkg::PRES_BIT]) begin
            pte[item.page_number][cpr_pkg::REF_BIT] = 1'b1;
            want.status      = cpr_pkg::STATUS_HIT;
            want.frame_idx   = pte[item.page_number][cpr_pkg::ENTRY_W-1:2];
            want.fault_total = fault_cnt;
         end else begin
            found  = 1'b0;
            victim = 0;
            frame  = '0;
            if (free_left != 0) begin
               free_left--;
               frame       = free_left;
               want.status = cpr_pkg::STATUS_FREE;
            end else begin
               if (hand_pos >= span) hand_pos = 0;
               // second chance: referenced pages lose their bit and are skipped
               for (steps = 0; steps <= 2 * span && !found; steps++) begin
                  if (pte[hand_pos][cpr_pkg::PRES_BIT] && !pte[hand_pos][cpr_pkg::REF_BIT]) begin
                     found  = 1'b1;
                     victim = hand_pos;
                  end else begin
                     pte[hand_pos][cpr_pkg::REF_BIT] = 1'b0;
                     hand_pos = (hand_pos + 1) % span;
                  end
               end
               if (found) begin
                  frame            = pte[victim][cpr_pkg::ENTRY_W-1:2];
                  pte[victim]      = '0;
                  want.victim_page = 8'(victim);
                  want.status      = cpr_pkg::STATUS_EVICT;
               end else begin
                  // nothing resident in range: lands in frame 0, no eviction
                  want.status = cpr_pkg::STATUS_FREE;
               end
            end
            pte[item.page_number] = {frame, 1'b1, 1'b1};
            if (fault_cnt != 16'hFFFF) fault_cnt++;
            want.frame_idx   = frame;
            want.fault_total = fault_cnt;
         end
         pending.push_back(want);
      endfunction

      task report(string what, int got, int want);
         $display("mismatch at %0t: %s = %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_result(cpr_pkg::rsp_type got);
         cpr_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report("result with no transaction outstanding, status", got.status, -1);
            return;
         end
         want = pending.pop_front();
         status_seen[want.status]++;
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.frame_idx !== want.frame_idx)
            report("frame_idx", got.frame_idx, want.frame_idx);
         if (got.victim_page !== want.victim_page)
            report("victim_page", got.victim_page, want.victim_page);
         if (got.fault_total !== want.fault_total)
            report("fault_total", got.fault_total, want.fault_total);
      endtask
   endclass

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   logic             busy;
   cpr_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   cpr_pkg::rsp_type rsp_data;
   logic             psel     = 1'b0;
   logic             penable  = 1'b0;
   logic             pwrite   = 1'b0;
   logic [2:0]       paddr    = '0;
   logic [31:0]      pwdata   = '0;
   logic [31:0]      prdata;
   logic             pready;

   int              idle_pct     = 0;
   int              quiet_cycles = 0;
   fault_scoreboard board;

   clock_page_replacement uut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_data);
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic cpr_pkg::req_type page_req(logic mode, logic [7:0] page);
      cpr_pkg::req_type item;
      item.mode        = mode;
      item.page_number = page;
      return item;
   endfunction

   // Mostly a small working set so hits and evictions both occur often.
   function automatic cpr_pkg::req_type random_item(int span, int hot);
      int roll;
      roll = $urandom_range(99);
      if (roll < 2) return page_req(cpr_pkg::MODE_RESTART, 8'($urandom));
      if (roll < 12) return page_req(cpr_pkg::MODE_REF, 8'($urandom_range(255)));
      if (roll < 75) return page_req(cpr_pkg::MODE_REF, 8'($urandom_range(hot - 1)));
      return page_req(cpr_pkg::MODE_REF, 8'($urandom_range(span - 1)));
   endfunction

   // Called just after a rising edge; start is left high when no gap follows.
   task automatic send_item(input cpr_pkg::req_type item);
      int gap;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      board.note_request(item);
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= page_req(1'($urandom), 8'($urandom));
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Leaves psel and penable high; configure drops them after the last write.
   task automatic write_reg(input logic index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_register(index, value);
   endtask

   task automatic configure(input int frames, input int pages);
      drain_results();
      write_reg(cpr_pkg::CSR_FRAME_COUNT, ($urandom & 32'hFFFF_FF00) | 32'(frames[7:0]));
      write_reg(cpr_pkg::CSR_PAGE_COUNT, ($urandom & 32'hFFFF_FE00) | 32'(pages[8:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      int phase;
      int frames;
      int pages;
      int span;
      int hot;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: four frames, full page range; fill, hit, then full sweeps
      send_item(page_req(cpr_pkg::MODE_REF, 8'd0));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd255));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd0));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd128));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd1));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd2));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd0));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd255));
      configure(4, 2);
      send_item(page_req(cpr_pkg::MODE_REF, 8'd2));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd255));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd1));
      configure(4, 0);
      send_item(page_req(cpr_pkg::MODE_REF, 8'd200));
      // no frames at all: first fault finds nothing to evict
      configure(0, 511);
      send_item(page_req(cpr_pkg::MODE_RESTART, 8'd0));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd5));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd6));
      // park the hand high, then shrink the page range beneath it
      configure(2, 256);
      send_item(page_req(cpr_pkg::MODE_RESTART, 8'd255));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd200));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd201));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd202));
      configure(2, 8);
      send_item(page_req(cpr_pkg::MODE_REF, 8'd3));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd4));
      configure(255, 256);
      send_item(page_req(cpr_pkg::MODE_RESTART, 8'd0));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd254));
      send_item(page_req(cpr_pkg::MODE_REF, 8'd7));

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin frames = 1;   pages = 2;   end
            1: begin frames = 255; pages = 256; end
            2: begin frames = 0;   pages = 16;  end
            3: begin frames = 255; pages = 2;   end
            4: begin frames = 6;   pages = 0;   end
            5: begin frames = 3;   pages = 511; end
            default: begin
               frames = $urandom_range(1, 12);
               pages  = ($urandom_range(3) == 0) ? 256 : $urandom_range(2, 40);
            end
         endcase
         configure(frames, pages);
         idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 86 : 27;
         // some phases keep the old table so a register write alone is seen to change nothing
         if (phase % 4 != 3) send_item(page_req(cpr_pkg::MODE_RESTART, 8'($urandom)));
         span = (pages == 0 || pages > PAGE_LIMIT) ? PAGE_LIMIT : pages;
         hot  = (frames + 2 < span) ? frames + 2 : span;
         repeat (PHASE_ITEMS) send_item(random_item(span, hot));
      end

      drain_results();
      repeat (4 * PAGE_LIMIT + 16) @(posedge clock);
      $display("hits %0d, free faults %0d, evictions %0d, rejects %0d, restarts %0d",
               board.status_seen[cpr_pkg::STATUS_HIT], board.status_seen[cpr_pkg::STATUS_FREE],
               board.status_seen[cpr_pkg::STATUS_EVICT],
               board.status_seen[cpr_pkg::STATUS_REJECT],
               board.status_seen[cpr_pkg::STATUS_RESTART]);
      $display("%0d random phases, extreme frame and page counts; %0d mismatches",
               RANDOM_PHASES, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/cpr_pkg.sv
src/cpr_ram.sv
src/clock_page_replacement.sv
tb/testbench.sv
